// ===== hw/rtl/sst_pkg.sv =====
// Shared constants, word types and state codes for the series stats trend accumulator.
`timescale 1ns / 1ps

package sst_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int SPAN_BITS   = 24;

	localparam int VAL_W   = 28;
	localparam int STAMP_W = 32;
	localparam int FRAC_W  = 16;
	localparam int SLOPE_W = 64;

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int X_W    = SPAN_BITS + 1;
	localparam int XY_W   = X_W + VAL_W;
	localparam int XX_W   = 2 * X_W;
	localparam int SUMX_W = X_W + CNT_W;
	localparam int VSUM_W = VAL_W + CNT_W;
	localparam int SXY_W  = XY_W + CNT_W;
	localparam int SXX_W  = XX_W + CNT_W;

	// widest of the four end-of-series products, plus one for the difference
	localparam int P_NXY  = CNT_W + SXY_W;
	localparam int P_XY   = SUMX_W + VSUM_W;
	localparam int P_NXX  = CNT_W + SXX_W;
	localparam int P_XX   = 2 * SUMX_W;
	localparam int P_M1   = (P_NXY > P_XY) ? P_NXY : P_XY;
	localparam int P_M2   = (P_NXX > P_XX) ? P_NXX : P_XX;
	localparam int PROD_W = ((P_M1 > P_M2) ? P_M1 : P_M2) + 1;

	localparam int QUO_W  = PROD_W + FRAC_W;
	localparam int EXT_W  = (QUO_W > SLOPE_W + 1) ? QUO_W : SLOPE_W + 1;
	localparam int STEP_W = $clog2(QUO_W + 1);

	localparam int QDEPTH = 4;
	localparam int QIDX_W = $clog2(QDEPTH);

	typedef struct packed {
		logic signed [VAL_W-1:0] sample_value;
		logic                    value_present;
		logic [STAMP_W-1:0]      stamp_seconds;
		logic                    stamp_ok;
		logic                    series_end;
	} sample_t;

	typedef struct packed {
		logic                    has_result;
		logic [CNT_W-1:0]        valid_count;
		logic signed [VAL_W-1:0] min_value;
		logic [STAMP_W-1:0]      min_stamp;
		logic                    min_stamp_ok;
		logic signed [VAL_W-1:0] max_value;
		logic [STAMP_W-1:0]      max_stamp;
		logic                    max_stamp_ok;
		logic signed [VAL_W-1:0] mean_value;
		logic signed [SLOPE_W-1:0] trend_slope;
		logic                    overflow_seen;
	} result_t;

	// queued word: only items that carry a value or close the series
	typedef struct packed {
		logic signed [VAL_W-1:0] sample_value;
		logic [STAMP_W-1:0]      stamp_seconds;
		logic                    stamp_ok;
		logic                    take;
		logic                    last;
	} entry_t;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_MLOAD,
		ST_MRUN,
		ST_MDONE,
		ST_SLOPE_SET,
		ST_DSLOPE,
		ST_SLOPE_FIX,
		ST_MEAN_SET,
		ST_DMEAN,
		ST_FINISH
	} back_state_t;

	typedef enum logic [1:0] {
		PROD_NXY,
		PROD_XY,
		PROD_NXX,
		PROD_XX
	} prod_sel_t;

endpackage

// ===== hw/rtl/sst_front.sv =====
// Input side: takes sample words, drops empty ones and builds queue entries.
`timescale 1ns / 1ps

module sst_front (
	input  logic             sample_valid,
	output logic             sample_stall,
	input  sst_pkg::sample_t sample,
	input  logic             q_full,
	output logic             q_push,
	output sst_pkg::entry_t  q_word
);

	logic keep;

	always_comb begin
		keep         = sample.value_present || sample.series_end;
		sample_stall = q_full;
		q_push       = sample_valid && !q_full && keep;

		q_word.sample_value  = sample.sample_value;
		// min/max report a zero stamp when it is not valid
		q_word.stamp_seconds = sample.stamp_ok ? sample.stamp_seconds : '0;
		q_word.stamp_ok      = sample.stamp_ok;
		q_word.take          = sample.value_present;
		q_word.last          = sample.series_end;
	end

endmodule

// ===== hw/rtl/sst_queue.sv =====
// Short word queue between the front and back parts.
`timescale 1ns / 1ps

module sst_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sst_pkg::entry_t wdata,
	input  logic            pop,
	output sst_pkg::entry_t rdata,
	output logic            full,
	output logic            empty
);

	localparam int DEPTH = sst_pkg::QDEPTH;
	localparam int IDX_W = sst_pkg::QIDX_W;

	sst_pkg::entry_t  slot_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		full    = cnt_q == (IDX_W + 1)'(DEPTH);
		empty   = cnt_q == '0;
		do_push = push && !full;
		do_pop  = pop && !empty;
		rdata   = slot_q[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= wdata;
	end

endmodule

// ===== hw/rtl/sst_back.sv =====
// Back part: accumulates queued samples and computes the series result.
`timescale 1ns / 1ps

module sst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  sst_pkg::entry_t  q_word,
	output logic             q_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output sst_pkg::result_t result
);

	localparam int MAX_SAMPLES = sst_pkg::MAX_SAMPLES;
	localparam int SPAN_BITS   = sst_pkg::SPAN_BITS;
	localparam int VAL_W       = sst_pkg::VAL_W;
	localparam int STAMP_W     = sst_pkg::STAMP_W;
	localparam int FRAC_W      = sst_pkg::FRAC_W;
	localparam int SLOPE_W     = sst_pkg::SLOPE_W;
	localparam int CNT_W       = sst_pkg::CNT_W;
	localparam int X_W         = sst_pkg::X_W;
	localparam int XY_W        = sst_pkg::XY_W;
	localparam int XX_W        = sst_pkg::XX_W;
	localparam int SUMX_W      = sst_pkg::SUMX_W;
	localparam int VSUM_W      = sst_pkg::VSUM_W;
	localparam int SXY_W       = sst_pkg::SXY_W;
	localparam int SXX_W       = sst_pkg::SXX_W;
	localparam int PROD_W      = sst_pkg::PROD_W;
	localparam int QUO_W       = sst_pkg::QUO_W;
	localparam int EXT_W       = sst_pkg::EXT_W;
	localparam int STEP_W      = sst_pkg::STEP_W;

	sst_pkg::back_state_t state_q;
	sst_pkg::back_state_t state_d;
	logic clr;
	logic fin_load;

	// series state
	logic [CNT_W-1:0]          present_count_q;
	logic [CNT_W-1:0]          point_count_q;
	logic signed [VSUM_W-1:0]  value_sum_q;
	logic signed [VAL_W-1:0]   low_value_q;
	logic [STAMP_W-1:0]        low_stamp_q;
	logic                      low_ok_q;
	logic signed [VAL_W-1:0]   high_value_q;
	logic [STAMP_W-1:0]        high_stamp_q;
	logic                      high_ok_q;
	logic [STAMP_W-1:0]        base_stamp_q;
	logic                      base_set_q;
	logic signed [SUMX_W-1:0]  sum_x_q;
	logic signed [VSUM_W-1:0]  sum_y_q;
	logic signed [SXY_W-1:0]   sum_xy_q;
	logic signed [SXX_W-1:0]   sum_xx_q;
	logic                      overflow_q;

	// product pipeline for the least-squares sums
	logic signed [X_W-1:0]     x_s1;
	logic signed [VAL_W-1:0]   v_s1;
	logic                      vld_s1;
	logic signed [XY_W-1:0]    xy_s2;
	logic signed [XX_W-1:0]    xx_s2;
	logic                      vld_s2;

	// shift-add multiplier and restoring divider
	sst_pkg::prod_sel_t        sel_q;
	logic [STEP_W-1:0]         step_q;
	logic [PROD_W-1:0]         mul_a_q;
	logic [SUMX_W-1:0]         mul_b_q;
	logic                      mul_sub_q;
	logic [PROD_W-1:0]         mul_acc_q;
	logic [PROD_W-1:0]         num_q;
	logic [PROD_W-1:0]         den_q;
	logic [QUO_W-1:0]          div_n_q;
	logic [PROD_W-1:0]         div_r_q;
	logic [PROD_W-1:0]         div_d_q;
	logic                      div_neg_q;
	logic [SLOPE_W-1:0]        slope_q;

	sst_pkg::result_t          res_q;
	logic                      res_valid_q;

	// accumulate-side decode
	logic signed [VAL_W-1:0]   v_in;
	logic [STAMP_W:0]          dx;
	logic [STAMP_W-SPAN_BITS:0] dx_hi;
	logic                      span_ok;
	logic                      cnt_full;
	logic                      use_x;
	logic                      drop;
	logic                      keep;
	logic                      pt_take;
	logic signed [X_W-1:0]     x_in;
	logic                      first;
	logic                      new_low;
	logic                      new_high;

	// end-of-series decode
	logic                      sx_neg;
	logic [SUMX_W-1:0]         sx_mag;
	logic [PROD_W-1:0]         mul_base;
	logic [PROD_W-1:0]         mul_res;
	logic [PROD_W-1:0]         num_mag;
	logic [PROD_W-1:0]         den_mag;
	logic                      slope_skip;
	logic [VSUM_W-1:0]         vs_mag;
	logic [PROD_W:0]           div_rs;
	logic [PROD_W:0]           div_diff;
	logic                      div_ge;
	logic [EXT_W-1:0]          qx;
	logic                      pos_sat;
	logic                      neg_sat;
	logic [SLOPE_W-1:0]        slope_fix;
	logic [VAL_W-1:0]          mean_fix;

	always_comb begin
		v_in     = q_word.sample_value;
		dx       = {1'b0, q_word.stamp_seconds} - {1'b0, base_stamp_q};
		dx_hi    = dx[STAMP_W:SPAN_BITS];
		// |dx| below 2^SPAN_BITS in both directions
		span_ok  = (dx_hi == '0) || ((dx_hi == '1) && (dx[SPAN_BITS-1:0] != '0));
		cnt_full = present_count_q >= CNT_W'(MAX_SAMPLES);
		use_x    = q_word.stamp_ok && base_set_q;
		drop     = q_word.take && (cnt_full || (use_x && !span_ok));
		keep     = q_pop && q_word.take && !drop;
		pt_take  = keep && q_word.stamp_ok;
		x_in     = use_x ? dx[X_W-1:0] : '0;
		first    = present_count_q == '0;
		new_low  = first || (v_in < low_value_q);
		new_high = first || (v_in >= high_value_q);
	end

	always_comb begin
		sx_neg = sum_x_q[SUMX_W-1];
		sx_mag = sx_neg ? (~sum_x_q + 1'b1) : sum_x_q;

		case (sel_q)
			sst_pkg::PROD_XY: mul_base = num_q;
			sst_pkg::PROD_XX: mul_base = den_q;
			default:          mul_base = '0;
		endcase
		mul_res = mul_sub_q ? (mul_base - mul_acc_q) : (mul_base + mul_acc_q);

		num_mag    = num_q[PROD_W-1] ? (~num_q + 1'b1) : num_q;
		den_mag    = den_q[PROD_W-1] ? (~den_q + 1'b1) : den_q;
		slope_skip = (point_count_q < CNT_W'(2)) || (den_q == '0);
		vs_mag     = value_sum_q[VSUM_W-1] ? (~value_sum_q + 1'b1) : value_sum_q;

		div_rs   = {div_r_q, div_n_q[QUO_W-1]};
		div_diff = div_rs - {1'b0, div_d_q};
		div_ge   = div_rs >= {1'b0, div_d_q};

		qx        = EXT_W'(div_n_q);
		pos_sat   = |qx[EXT_W-1:SLOPE_W-1];
		neg_sat   = (|qx[EXT_W-1:SLOPE_W]) || (qx[SLOPE_W-1] && (|qx[SLOPE_W-2:0]));
		if (div_neg_q)
			slope_fix = neg_sat ? {1'b1, {(SLOPE_W-1){1'b0}}} : (~qx[SLOPE_W-1:0] + 1'b1);
		else
			slope_fix = pos_sat ? {1'b0, {(SLOPE_W-1){1'b1}}} : qx[SLOPE_W-1:0];
		mean_fix = div_neg_q ? (~div_n_q[VAL_W-1:0] + 1'b1) : div_n_q[VAL_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sst_pkg::ST_ACCUM;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		clr      = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			sst_pkg::ST_ACCUM: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_word.last) state_d = sst_pkg::ST_DRAIN;
				end
			end
			sst_pkg::ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					if (present_count_q == '0) begin
						clr     = 1'b1;
						state_d = sst_pkg::ST_ACCUM;
					end else begin
						state_d = sst_pkg::ST_MLOAD;
					end
				end
			end
			sst_pkg::ST_MLOAD: state_d = sst_pkg::ST_MRUN;
			sst_pkg::ST_MRUN: begin
				if (step_q == STEP_W'(SUMX_W - 1)) state_d = sst_pkg::ST_MDONE;
			end
			sst_pkg::ST_MDONE: begin
				if (sel_q == sst_pkg::PROD_XX) state_d = sst_pkg::ST_SLOPE_SET;
				else state_d = sst_pkg::ST_MLOAD;
			end
			sst_pkg::ST_SLOPE_SET: begin
				state_d = slope_skip ? sst_pkg::ST_MEAN_SET : sst_pkg::ST_DSLOPE;
			end
			sst_pkg::ST_DSLOPE: begin
				if (step_q == STEP_W'(QUO_W - 1)) state_d = sst_pkg::ST_SLOPE_FIX;
			end
			sst_pkg::ST_SLOPE_FIX: state_d = sst_pkg::ST_MEAN_SET;
			sst_pkg::ST_MEAN_SET: state_d = sst_pkg::ST_DMEAN;
			sst_pkg::ST_DMEAN: begin
				if (step_q == STEP_W'(QUO_W - 1)) state_d = sst_pkg::ST_FINISH;
			end
			sst_pkg::ST_FINISH: begin
				if (!res_valid_q || !result_stall) begin
					fin_load = 1'b1;
					clr      = 1'b1;
					state_d  = sst_pkg::ST_ACCUM;
				end
			end
			default: state_d = sst_pkg::ST_ACCUM;
		endcase
	end

	// running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_count_q <= '0;
			point_count_q   <= '0;
			value_sum_q     <= '0;
			low_value_q     <= '0;
			low_stamp_q     <= '0;
			low_ok_q        <= 1'b0;
			high_value_q    <= '0;
			high_stamp_q    <= '0;
			high_ok_q       <= 1'b0;
			base_stamp_q    <= '0;
			base_set_q      <= 1'b0;
			sum_x_q         <= '0;
			sum_y_q         <= '0;
			sum_xy_q        <= '0;
			sum_xx_q        <= '0;
			overflow_q      <= 1'b0;
		end else if (clr) begin
			present_count_q <= '0;
			point_count_q   <= '0;
			value_sum_q     <= '0;
			low_value_q     <= '0;
			low_stamp_q     <= '0;
			low_ok_q        <= 1'b0;
			high_value_q    <= '0;
			high_stamp_q    <= '0;
			high_ok_q       <= 1'b0;
			base_stamp_q    <= '0;
			base_set_q      <= 1'b0;
			sum_x_q         <= '0;
			sum_y_q         <= '0;
			sum_xy_q        <= '0;
			sum_xx_q        <= '0;
			overflow_q      <= 1'b0;
		end else begin
			if (q_pop && drop) overflow_q <= 1'b1;
			if (keep) begin
				present_count_q <= present_count_q + 1'b1;
				value_sum_q     <= value_sum_q + VSUM_W'(v_in);
				if (new_low) begin
					low_value_q <= v_in;
					low_stamp_q <= q_word.stamp_seconds;
					low_ok_q    <= q_word.stamp_ok;
				end
				if (new_high) begin
					high_value_q <= v_in;
					high_stamp_q <= q_word.stamp_seconds;
					high_ok_q    <= q_word.stamp_ok;
				end
			end
			if (pt_take) begin
				if (!base_set_q) begin
					base_stamp_q <= q_word.stamp_seconds;
					base_set_q   <= 1'b1;
				end
				point_count_q <= point_count_q + 1'b1;
				sum_x_q       <= sum_x_q + SUMX_W'(x_in);
				sum_y_q       <= sum_y_q + VSUM_W'(v_in);
			end
			if (vld_s2) begin
				sum_xy_q <= sum_xy_q + SXY_W'(xy_s2);
				sum_xx_q <= sum_xx_q + SXX_W'(xx_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= pt_take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= x_in;
		v_s1  <= v_in;
		xy_s2 <= x_s1 * v_s1;
		xx_s2 <= x_s1 * x_s1;
	end

	// end-of-series datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sst_pkg::ST_DRAIN: sel_q <= sst_pkg::PROD_NXY;
			sst_pkg::ST_MLOAD: begin
				step_q    <= '0;
				mul_acc_q <= '0;
				case (sel_q)
					sst_pkg::PROD_NXY: begin
						mul_a_q   <= PROD_W'(sum_xy_q);
						mul_b_q   <= SUMX_W'(point_count_q);
						mul_sub_q <= 1'b0;
					end
					sst_pkg::PROD_XY: begin
						mul_a_q   <= PROD_W'(sum_y_q);
						mul_b_q   <= sx_mag;
						mul_sub_q <= !sx_neg;
					end
					sst_pkg::PROD_NXX: begin
						mul_a_q   <= PROD_W'(sum_xx_q);
						mul_b_q   <= SUMX_W'(point_count_q);
						mul_sub_q <= 1'b0;
					end
					default: begin
						mul_a_q   <= PROD_W'(sum_x_q);
						mul_b_q   <= sx_mag;
						mul_sub_q <= !sx_neg;
					end
				endcase
			end
			sst_pkg::ST_MRUN: begin
				if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
				mul_a_q <= {mul_a_q[PROD_W-2:0], 1'b0};
				mul_b_q <= {1'b0, mul_b_q[SUMX_W-1:1]};
				step_q  <= step_q + 1'b1;
			end
			sst_pkg::ST_MDONE: begin
				case (sel_q)
					sst_pkg::PROD_NXY: begin
						num_q <= mul_res;
						sel_q <= sst_pkg::PROD_XY;
					end
					sst_pkg::PROD_XY: begin
						num_q <= mul_res;
						sel_q <= sst_pkg::PROD_NXX;
					end
					sst_pkg::PROD_NXX: begin
						den_q <= mul_res;
						sel_q <= sst_pkg::PROD_XX;
					end
					default: den_q <= mul_res;
				endcase
			end
			sst_pkg::ST_SLOPE_SET: begin
				step_q    <= '0;
				slope_q   <= '0;
				div_r_q   <= '0;
				div_n_q   <= {num_mag, {FRAC_W{1'b0}}};
				div_d_q   <= den_mag;
				div_neg_q <= num_q[PROD_W-1] ^ den_q[PROD_W-1];
			end
			sst_pkg::ST_DSLOPE, sst_pkg::ST_DMEAN: begin
				div_r_q <= div_ge ? div_diff[PROD_W-1:0] : div_rs[PROD_W-1:0];
				div_n_q <= {div_n_q[QUO_W-2:0], div_ge};
				step_q  <= step_q + 1'b1;
			end
			sst_pkg::ST_SLOPE_FIX: slope_q <= slope_fix;
			sst_pkg::ST_MEAN_SET: begin
				step_q    <= '0;
				div_r_q   <= '0;
				div_n_q   <= QUO_W'(vs_mag);
				div_d_q   <= PROD_W'(present_count_q);
				div_neg_q <= value_sum_q[VSUM_W-1];
			end
			default: ;
		endcase
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (fin_load) res_valid_q <= 1'b1;
		else if (!result_stall) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			res_q.has_result    <= 1'b1;
			res_q.valid_count   <= present_count_q;
			res_q.min_value     <= low_value_q;
			res_q.min_stamp     <= low_stamp_q;
			res_q.min_stamp_ok  <= low_ok_q;
			res_q.max_value     <= high_value_q;
			res_q.max_stamp     <= high_stamp_q;
			res_q.max_stamp_ok  <= high_ok_q;
			res_q.mean_value    <= mean_fix;
			res_q.trend_slope   <= slope_q;
			res_q.overflow_seen <= overflow_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hw/rtl/series_stats_trend_accumulator.sv =====
// Series stats trend accumulator: count, extremes, mean and least-squares slope per series.
// Samples enter a 4-word queue one per cycle unless it is full, and are accumulated one
// per cycle while the back part accumulates. A series-end word drains the product pipeline
// and, if a sample was kept, runs four shift-add products and restoring divides for the
// slope (when defined) and mean; the queue keeps taking words meanwhile until it fills,
// then stall rises. Asynchronous active-low reset clears all series state and result_valid.
`timescale 1ns / 1ps

module series_stats_trend_accumulator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  sst_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output sst_pkg::result_t result
);

	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;
	sst_pkg::entry_t push_word;
	sst_pkg::entry_t head_word;

	sst_front u_front (
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_word       (push_word)
	);

	sst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_word),
		.pop    (q_pop),
		.rdata  (head_word),
		.full   (q_full),
		.empty  (q_empty)
	);

	sst_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_word       (head_word),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== tb/series_stats_trend_accumulator_tb.sv =====
// Self-checking testbench for the series stats trend accumulator: directed and random series.
`timescale 1ns / 1ps

module series_stats_trend_accumulator_tb;

	localparam logic signed [sst_pkg::VAL_W-1:0] V_MAX = {1'b0, {(sst_pkg::VAL_W-1){1'b1}}};
	localparam logic signed [sst_pkg::VAL_W-1:0] V_MIN = {1'b1, {(sst_pkg::VAL_W-1){1'b0}}};

	// Tracks per-series statistics and holds the results the block owes us.
	class series_stats_checker;
		int              n_present;
		int              n_points;
		longint          val_total;
		logic signed [sst_pkg::VAL_W-1:0] lo_val, hi_val;
		logic [sst_pkg::STAMP_W-1:0]      lo_t, hi_t;
		bit              lo_t_ok, hi_t_ok;
		longint          t0;
		bit              t0_set;
		longint          acc_x, acc_y, acc_xy, acc_xx;
		bit              dropped;
		sst_pkg::result_t pending_results[$];
		int              errors;

		function new();
			errors = 0;
			clear_series();
		endfunction

		function void clear_series();
			n_present = 0;
			n_points  = 0;
			val_total = 0;
			lo_val    = '0;
			hi_val    = '0;
			lo_t      = '0;
			hi_t      = '0;
			lo_t_ok   = 0;
			hi_t_ok   = 0;
			t0        = 0;
			t0_set    = 0;
			acc_x     = 0;
			acc_y     = 0;
			acc_xy    = 0;
			acc_xx    = 0;
			dropped   = 0;
		endfunction

		function void note_sample(sst_pkg::sample_t w);
			longint v, st, x, span_lim;
			bit keep;
			sst_pkg::result_t r;
			logic signed [127:0] nw, sxw, syw, sxyw, sxxw, num, den, q;
			v = $signed(w.sample_value);
			st = w.stamp_seconds;
			span_lim = longint'(1) << sst_pkg::SPAN_BITS;
			if (w.value_present) begin
				x = 0;
				keep = 1;
				if (n_present >= sst_pkg::MAX_SAMPLES) begin
					keep = 0;
				end else if (w.stamp_ok && t0_set) begin
					x = st - t0;
					if (x >= span_lim || x <= -span_lim)
						keep = 0;
				end
				if (!keep) begin
					dropped = 1;
				end else begin
					if (n_present == 0 || w.sample_value < lo_val) begin
						lo_val  = w.sample_value;
						lo_t    = w.stamp_ok ? w.stamp_seconds : '0;
						lo_t_ok = w.stamp_ok;
					end
					if (n_present == 0 || w.sample_value >= hi_val) begin
						hi_val  = w.sample_value;
						hi_t    = w.stamp_ok ? w.stamp_seconds : '0;
						hi_t_ok = w.stamp_ok;
					end
					n_present++;
					val_total += v;
					if (w.stamp_ok) begin
						if (!t0_set) begin
							t0     = st;
							t0_set = 1;
							x      = 0;
						end
						n_points++;
						acc_x  += x;
						acc_y  += v;
						acc_xy += x * v;
						acc_xx += x * x;
					end
				end
			end
			if (!w.series_end)
				return;
			if (n_present > 0) begin
				r.has_result    = 1'b1;
				r.valid_count   = n_present[sst_pkg::CNT_W-1:0];
				r.min_value     = lo_val;
				r.min_stamp     = lo_t;
				r.min_stamp_ok  = lo_t_ok;
				r.max_value     = hi_val;
				r.max_stamp     = hi_t;
				r.max_stamp_ok  = hi_t_ok;
				r.mean_value    = sst_pkg::VAL_W'(val_total / longint'(n_present));
				r.overflow_seen = dropped;
				r.trend_slope   = '0;
				if (n_points >= 2) begin
					nw   = n_points;
					sxw  = acc_x;
					syw  = acc_y;
					sxyw = acc_xy;
					sxxw = acc_xx;
					den  = nw * sxxw - sxw * sxw;
					if (den != 0) begin
						num = (nw * sxyw - sxw * syw) <<< sst_pkg::FRAC_W;
						q   = num / den;
						// saturate to the signed 64-bit range
						if (q > $signed({64'h0, 64'h7FFF_FFFF_FFFF_FFFF}))
							r.trend_slope = 64'h7FFF_FFFF_FFFF_FFFF;
						else if (q < $signed({{64{1'b1}}, 64'h8000_0000_0000_0000}))
							r.trend_slope = 64'h8000_0000_0000_0000;
						else
							r.trend_slope = q[sst_pkg::SLOPE_W-1:0];
					end
				end
				pending_results = {pending_results, r};
			end
			clear_series();
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task field_check(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_result(sst_pkg::result_t got);
			sst_pkg::result_t want;
			if (pending_results.size() == 0) begin
				report("result word with none outstanding");
				return;
			end
			want = pending_results.pop_front();
			field_check("has_result", got.has_result, want.has_result);
			field_check("valid_count", got.valid_count, want.valid_count);
			field_check("min_value", got.min_value, want.min_value);
			field_check("min_stamp", got.min_stamp, want.min_stamp);
			field_check("min_stamp_ok", got.min_stamp_ok, want.min_stamp_ok);
			field_check("max_value", got.max_value, want.max_value);
			field_check("max_stamp", got.max_stamp, want.max_stamp);
			field_check("max_stamp_ok", got.max_stamp_ok, want.max_stamp_ok);
			field_check("mean_value", got.mean_value, want.mean_value);
			field_check("trend_slope", got.trend_slope, want.trend_slope);
			field_check("overflow_seen", got.overflow_seen, want.overflow_seen);
		endtask
	endclass

	logic             clk;
	logic             arst_n       = 1'b0;
	logic             sample_valid = 1'b0;
	logic             sample_stall;
	sst_pkg::sample_t sample       = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	sst_pkg::result_t result;

	series_stats_checker sb;
	int src_idle   = 0;
	int dst_idle   = 0;
	int words_sent = 0;

	series_stats_trend_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hang guard, sized for every word closing a series under heavy stalls
	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < dst_idle);
	end

	// values read here are the ones settled before the edge
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	task automatic send_word(input sst_pkg::sample_t w);
		while ($urandom_range(99) < src_idle) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= w;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sb.note_sample(w);
		words_sent++;
	endtask

	task automatic put(input logic signed [sst_pkg::VAL_W-1:0] v, input bit pres,
			input logic [sst_pkg::STAMP_W-1:0] t, input bit ok, input bit last);
		sst_pkg::sample_t w;
		w.sample_value  = v;
		w.value_present = pres;
		w.stamp_seconds = t;
		w.stamp_ok      = ok;
		w.series_end    = last;
		send_word(w);
	endtask

	// tmode: 0 non-decreasing, 1 within span, 2 all equal, 3 near span edge, 4 anywhere
	task automatic random_series(input int len, input int present_pct, input int tmode);
		sst_pkg::sample_t w;
		int vmode;
		longint base_t, t;
		logic [31:0] raw;
		vmode  = $urandom_range(3);
		base_t = $urandom_range(32'hFE00_0000, 32'h0200_0000);
		t      = base_t;
		for (int i = 0; i < len; i++) begin
			raw = $urandom;
			case (vmode)
				0: w.sample_value = raw[sst_pkg::VAL_W-1:0];
				1: w.sample_value = sst_pkg::VAL_W'($urandom_range(4)) - sst_pkg::VAL_W'(2);
				2: begin
					case (raw[1:0])
						2'd0: w.sample_value = V_MAX;
						2'd1: w.sample_value = V_MIN;
						2'd2: w.sample_value = '0;
						default: w.sample_value = '1;
					endcase
				end
				default: w.sample_value = sst_pkg::VAL_W'($urandom_range(2000))
					- sst_pkg::VAL_W'(1000);
			endcase
			case (tmode)
				0: t = t + $urandom_range(50);
				1: t = base_t - (1 << 23) + $urandom_range((1 << 24) - 1);
				2: t = base_t;
				3: t = base_t - (1 << 24) + $urandom_range(1 << 25);
				default: t = $urandom;
			endcase
			w.stamp_seconds = t[sst_pkg::STAMP_W-1:0];
			w.value_present = ($urandom_range(99) < present_pct);
			w.stamp_ok      = ($urandom_range(99) < 85);
			w.series_end    = (i == len - 1);
			send_word(w);
		end
	endtask

	task automatic run_phase(input int src, input int dst, input int target);
		int start;
		int len;
		src_idle = src;
		dst_idle = dst;
		start    = words_sent;
		while (words_sent - start < target) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
			// a few mostly-empty series as noise
			random_series(len, ($urandom_range(9) == 0) ? 5 : 90, $urandom_range(4));
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		src_idle = 25;
		dst_idle = 77;

		// empty series gives no word back
		put(0, 0, 32'h0000_1234, 1, 1);
		// extremes with ties: first minimum, last maximum
		put(V_MAX, 1, 32'h0000_0000, 1, 0);
		put(V_MIN, 1, 32'h0000_0001, 1, 0);
		put(V_MIN, 1, 32'h0000_0002, 1, 0);
		put(V_MAX, 1, 32'h0000_0003, 1, 1);
		// min and max from samples with bad stamps, single slope point
		put(5, 1, 32'hFFFF_FFFF, 0, 0);
		put(-5, 1, 32'h0000_007B, 0, 0);
		put(1, 1, 32'h0000_0010, 1, 1);
		// span edges around the base stamp, series closed by a dropped sample
		put(1, 1, 32'h8000_0000, 1, 0);
		put(2, 1, 32'h80FF_FFFF, 1, 0);
		put(3, 1, 32'h8100_0000, 1, 0);
		put(4, 1, 32'h7F00_0000, 1, 0);
		put(7, 1, 32'h7F00_0001, 1, 0);
		put(8, 0, 32'hFFFF_FFFF, 1, 0);
		put(9, 1, 32'h8200_0000, 1, 1);
		// all times equal: zero denominator
		put(10, 1, 32'hFFFF_FFFF, 1, 0);
		put(20, 1, 32'hFFFF_FFFF, 1, 1);
		// negative mean truncates toward zero; overflow not carried from the span-edge series
		put(-3, 1, 32'h0000_0064, 1, 0);
		put(-4, 1, 32'h0000_0065, 1, 1);

		run_phase(25, 77, 230);
		run_phase(77, 25, 230);
		run_phase(0, 0, 230);
		// runs past the sample count limit
		random_series(sst_pkg::MAX_SAMPLES + 6, 100, 0);

		sample_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/sst_pkg.sv
hw/rtl/sst_front.sv
hw/rtl/sst_queue.sv
hw/rtl/sst_back.sv
hw/rtl/series_stats_trend_accumulator.sv
tb/series_stats_trend_accumulator_tb.sv
